// ===== rtl/core/slau_pkg.sv =====
// ----------------------------------------------------------------------------
// slau_pkg
// types and constants shared by the simd lane access unit
// ----------------------------------------------------------------------------
package slau_pkg;

	localparam int unsigned VEC_BYTES   = 16;
	localparam int unsigned IN_TDATA_W  = 408;
	localparam int unsigned OUT_TDATA_W = 192;

	// operation carried in tuser
	typedef enum logic [1:0] {
		KIND_SHUFFLE = 2'd0,
		KIND_SWIZZLE = 2'd1,
		KIND_EXTRACT = 2'd2,
		KIND_REPLACE = 2'd3
	} kind_t;

	// lane width of extract and replace
	typedef enum logic [1:0] {
		SHAPE_I8  = 2'd0,
		SHAPE_I16 = 2'd1,
		SHAPE_I32 = 2'd2,
		SHAPE_I64 = 2'd3
	} shape_t;

	// per-item controls broadcast to the byte lanes and the merge stage
	typedef struct packed {
		kind_t       kind;
		shape_t      shape;
		logic [3:0]  lane_index;
	} lane_ctrl_t;

	// input tdata layout, last field in the lowest bits
	typedef struct packed {
		logic [63:0] scalar_in;
		logic        sign_extend;
		logic [3:0]  lane_index;
		logic [1:0]  lane_shape;
		logic [39:0] pick_hi;
		logic [39:0] pick_lo;
		logic [63:0] vec_b_hi;
		logic [63:0] vec_b_lo;
		logic [63:0] vec_a_hi;
		logic [63:0] vec_a_lo;
	} in_data_t;

endpackage

// ===== rtl/core/slau_byte_lane.sv =====
// ----------------------------------------------------------------------------
// slau_byte_lane
// produces one result byte for shuffle, swizzle and replace
// ----------------------------------------------------------------------------
module slau_byte_lane (
	input  slau_pkg::lane_ctrl_t ctrl,
	input  logic [3:0]           lane_id,
	input  logic [15:0][7:0]     vec_a,
	input  logic [15:0][7:0]     vec_b,
	input  logic [4:0]           pick,
	input  logic [63:0]          scalar_in,
	output logic [7:0]           lane_byte
);

	logic [31:0][7:0] src;
	logic [7:0][7:0]  scalar_bytes;
	logic [7:0]       swz_idx;
	logic [3:0]       own_lane;
	logic [3:0]       lane_mask;
	logic [2:0]       byte_sel;
	logic             hit;

	assign src          = {vec_b, vec_a};
	assign scalar_bytes = scalar_in;
	assign swz_idx      = vec_b[lane_id];

	// which lane of the shape this byte belongs to, and its byte within it
	always_comb begin
		unique case (ctrl.shape)
			slau_pkg::SHAPE_I8: begin
				own_lane  = lane_id;
				byte_sel  = 3'd0;
				lane_mask = 4'hF;
			end
			slau_pkg::SHAPE_I16: begin
				own_lane  = {1'b0, lane_id[3:1]};
				byte_sel  = {2'b00, lane_id[0]};
				lane_mask = 4'h7;
			end
			slau_pkg::SHAPE_I32: begin
				own_lane  = {2'b00, lane_id[3:2]};
				byte_sel  = {1'b0, lane_id[1:0]};
				lane_mask = 4'h3;
			end
			slau_pkg::SHAPE_I64: begin
				own_lane  = {3'b000, lane_id[3]};
				byte_sel  = lane_id[2:0];
				lane_mask = 4'h1;
			end
			default: begin
				own_lane  = lane_id;
				byte_sel  = 3'd0;
				lane_mask = 4'hF;
			end
		endcase
	end

	assign hit = (own_lane == (ctrl.lane_index & lane_mask));

	always_comb begin
		unique case (ctrl.kind)
			slau_pkg::KIND_SHUFFLE: lane_byte = src[pick];
			// indices of sixteen and up give zero
			slau_pkg::KIND_SWIZZLE: lane_byte = (swz_idx[7:4] != 4'd0) ? 8'h00
			                                    : vec_a[swz_idx[3:0]];
			slau_pkg::KIND_EXTRACT: lane_byte = 8'h00;
			slau_pkg::KIND_REPLACE: lane_byte = hit ? scalar_bytes[byte_sel]
			                                    : vec_a[lane_id];
			default:                lane_byte = 8'h00;
		endcase
	end

endmodule

// ===== rtl/core/slau_merge.sv =====
// ----------------------------------------------------------------------------
// slau_merge
// gathers the lane bytes into the result vector and performs lane extract
// ----------------------------------------------------------------------------
module slau_merge (
	input  slau_pkg::lane_ctrl_t ctrl,
	input  logic                 sign_extend,
	input  logic [127:0]         vec_a,
	input  logic [15:0][7:0]     lane_bytes,
	output logic [127:0]         result,
	output logic [63:0]          scalar_out
);

	logic [15:0][7:0]  a8;
	logic [7:0][15:0]  a16;
	logic [3:0][31:0]  a32;
	logic [1:0][63:0]  a64;
	logic [7:0]        v8;
	logic [15:0]       v16;
	logic [63:0]       lane_val;

	assign a8     = vec_a;
	assign a16    = vec_a;
	assign a32    = vec_a;
	assign a64    = vec_a;
	assign v8     = a8[ctrl.lane_index];
	assign v16    = a16[ctrl.lane_index[2:0]];
	assign result = lane_bytes;

	always_comb begin
		unique case (ctrl.shape)
			slau_pkg::SHAPE_I8:  lane_val = {32'h0, {24{sign_extend & v8[7]}}, v8};
			slau_pkg::SHAPE_I16: lane_val = {32'h0, {16{sign_extend & v16[15]}}, v16};
			slau_pkg::SHAPE_I32: lane_val = {32'h0, a32[ctrl.lane_index[1:0]]};
			slau_pkg::SHAPE_I64: lane_val = a64[ctrl.lane_index[0]];
			default:             lane_val = 64'h0;
		endcase
	end

	assign scalar_out = (ctrl.kind == slau_pkg::KIND_EXTRACT) ? lane_val : 64'h0;

endmodule

// ===== rtl/core/simd_lane_access_unit_core.sv =====
// ----------------------------------------------------------------------------
// simd_lane_access_unit_core: shuffle, swizzle, extract and replace lane
// the result reaches the master side in the cycle after its input transfer
// throughput: one item per cycle while m_tready accepts results; a single output register
// reset: arst_n clears the output valid flag, payload registers are not reset
// ----------------------------------------------------------------------------
module simd_lane_access_unit_core (
	input  logic         clk,
	input  logic         arst_n,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// tuser: kind[1:0]
	input  logic [1:0]   s_tuser,
	// tdata: vec_a_lo[63:0], vec_a_hi[127:64], vec_b_lo[191:128],
	// vec_b_hi[255:192], pick_lo[295:256], pick_hi[335:296],
	// lane_shape[337:336], lane_index[341:338], sign_extend[342],
	// scalar_in[406:343], zero pad[407]
	input  logic [407:0] s_tdata,
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: result_lo[63:0], result_hi[127:64], scalar_out[191:128]
	output logic [191:0] m_tdata
);

	slau_pkg::in_data_t   in_d;
	slau_pkg::lane_ctrl_t ctrl;
	logic [15:0][4:0]     picks;
	logic [15:0][7:0]     vec_a;
	logic [15:0][7:0]     vec_b;
	logic [15:0][7:0]     lane_bytes;
	logic [127:0]         result;
	logic [63:0]          scalar_out;

	logic                 valid_s1;
	logic [127:0]         result_s1;
	logic [63:0]          scalar_s1;
	logic                 load;

	// unpack the transfer
	assign in_d            = s_tdata[406:0];
	assign vec_a           = {in_d.vec_a_hi, in_d.vec_a_lo};
	assign vec_b           = {in_d.vec_b_hi, in_d.vec_b_lo};
	assign picks           = {in_d.pick_hi, in_d.pick_lo};
	assign ctrl.kind       = slau_pkg::kind_t'(s_tuser);
	assign ctrl.shape      = slau_pkg::shape_t'(in_d.lane_shape);
	assign ctrl.lane_index = in_d.lane_index;

	// sixteen byte lanes work side by side, one per result byte
	for (genvar i = 0; i < slau_pkg::VEC_BYTES; i++) begin : g_lane
		slau_byte_lane u_lane (
			.ctrl      (ctrl),
			.lane_id   (4'(i)),
			.vec_a     (vec_a),
			.vec_b     (vec_b),
			.pick      (picks[i]),
			.scalar_in (in_d.scalar_in),
			.lane_byte (lane_bytes[i])
		);
	end

	// merge stage: result vector from the lanes plus the extracted scalar
	slau_merge u_merge (
		.ctrl        (ctrl),
		.sign_extend (in_d.sign_extend),
		.vec_a       (vec_a),
		.lane_bytes  (lane_bytes),
		.result      (result),
		.scalar_out  (scalar_out)
	);

	// output register; a new item moves in whenever the register is empty or the old one leaves
	assign s_tready = !valid_s1 || m_tready;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload holds while a result stalls
	always_ff @(posedge clk) begin
		if (load) begin
			result_s1 <= result;
			scalar_s1 <= scalar_out;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {scalar_s1, result_s1};

endmodule

// ===== rtl/core/slau_checker.sv =====
// ----------------------------------------------------------------------------
// slau_checker
// port level checks on the simd lane access unit
// ----------------------------------------------------------------------------
module slau_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output register never stalls the slave side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// an extract transfer shows up next cycle with a zero vector
	a_extract_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == slau_pkg::KIND_EXTRACT)
		|=> m_tvalid && (m_tdata[127:0] == 128'h0))
		else $error("extract result vector not zero");

	// vector operations leave the scalar field clear
	a_vector_scalar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != slau_pkg::KIND_EXTRACT)
		|=> m_tvalid && (m_tdata[191:128] == 64'h0))
		else $error("scalar field not zero on vector operation");

endmodule

bind simd_lane_access_unit_core slau_checker u_slau_checker (.*);
